// ===== hw/rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Shared types and constants for the bus step logic and the top level.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;

  localparam logic [3:0] BIT_COUNT_LAST   = 4'(BITS_PER_BYTE);
  localparam logic [7:0] ACK_TIMEOUT_RST  = 8'd250;

  localparam logic [2:0] FUNC_NONE  = 3'd0;
  localparam logic [2:0] FUNC_START = 3'd1;
  localparam logic [2:0] FUNC_STOP  = 3'd2;
  localparam logic [2:0] FUNC_WRITE = 3'd3;
  localparam logic [2:0] FUNC_READ  = 3'd4;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START_B  = 4'd1,
    PH_START_C  = 4'd2,
    PH_STOP_B   = 4'd3,
    PH_STOP_C   = 4'd4,
    PH_WR_HIGH  = 4'd5,
    PH_WR_LOW   = 4'd6,
    PH_WR_DATA  = 4'd7,
    PH_ACK_REL  = 4'd8,
    PH_ACK_CLK  = 4'd9,
    PH_ACK_POLL = 4'd10,
    PH_RD_HIGH  = 4'd11,
    PH_RD_LOW   = 4'd12,
    PH_RA_HIGH  = 4'd13,
    PH_RA_END   = 4'd14
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  bit_count;
    logic [7:0]  shift_reg;
    logic [7:0]  wait_count;
    logic        ack_choice;
    logic        scl;
    logic        sda;
    logic [7:0]  rx_hold;
  } eng_state_t;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] tx_byte;
    logic       ack_after_read;
    logic       sda_sample;
  } tick_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic status;
  } step_flags_t;

  localparam eng_state_t ENG_STATE_RST = '{
    phase:      PH_IDLE,
    bit_count:  4'd0,
    shift_reg:  8'd0,
    wait_count: 8'd0,
    ack_choice: 1'b0,
    scl:        1'b1,
    sda:        1'b1,
    rx_hold:    8'd0
  };

endpackage

// ===== hw/rtl/i2cm_step.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine step logic
// Works out the engine state after one bus tick and the flags of that tick.
// ----------------------------------------------------------------------------
module i2cm_step (
  input  i2cm_pkg::eng_state_t  st,
  input  i2cm_pkg::tick_t       tick,
  input  logic [7:0]            ack_timeout,
  output i2cm_pkg::eng_state_t  st_nxt,
  output i2cm_pkg::step_flags_t flags
);
  import i2cm_pkg::*;

  logic [3:0] rd_count;

  assign rd_count = st.bit_count + 4'd1;

  always_comb begin
    st_nxt       = st;
    flags.busy   = 1'b1;
    flags.done   = 1'b0;
    flags.status = 1'b0;
    case (st.phase)
      PH_IDLE: begin
        flags.busy = 1'b0;
        case (tick.func)
          FUNC_START: begin
            flags.busy   = 1'b1;
            st_nxt.sda   = 1'b1;
            st_nxt.scl   = 1'b1;
            st_nxt.phase = PH_START_B;
          end
          FUNC_STOP: begin
            flags.busy   = 1'b1;
            st_nxt.sda   = 1'b0;
            st_nxt.scl   = 1'b0;
            st_nxt.phase = PH_STOP_B;
          end
          FUNC_WRITE: begin
            flags.busy       = 1'b1;
            st_nxt.scl       = 1'b0;
            st_nxt.sda       = tick.tx_byte[BITS_PER_BYTE-1];
            st_nxt.shift_reg = {tick.tx_byte[BITS_PER_BYTE-2:0], 1'b0};
            st_nxt.bit_count = 4'd1;
            st_nxt.phase     = PH_WR_HIGH;
          end
          FUNC_READ: begin
            flags.busy        = 1'b1;
            st_nxt.sda        = 1'b1;
            st_nxt.scl        = 1'b0;
            st_nxt.shift_reg  = 8'd0;
            st_nxt.bit_count  = 4'd0;
            st_nxt.ack_choice = tick.ack_after_read;
            st_nxt.phase      = PH_RD_HIGH;
          end
          default: begin
          end
        endcase
      end
      PH_START_B: begin
        st_nxt.sda   = 1'b0;
        st_nxt.phase = PH_START_C;
      end
      PH_START_C: begin
        st_nxt.scl = 1'b0;
        flags.done = 1'b1;
      end
      PH_STOP_B: begin
        st_nxt.scl   = 1'b1;
        st_nxt.phase = PH_STOP_C;
      end
      PH_STOP_C: begin
        st_nxt.sda = 1'b1;
        flags.done = 1'b1;
      end
      PH_WR_HIGH: begin
        st_nxt.scl   = 1'b1;
        st_nxt.phase = PH_WR_LOW;
      end
      PH_WR_LOW: begin
        st_nxt.scl   = 1'b0;
        st_nxt.phase = (st.bit_count >= BIT_COUNT_LAST) ? PH_ACK_REL : PH_WR_DATA;
      end
      PH_WR_DATA: begin
        st_nxt.sda       = st.shift_reg[BITS_PER_BYTE-1];
        st_nxt.shift_reg = {st.shift_reg[BITS_PER_BYTE-2:0], 1'b0};
        st_nxt.bit_count = rd_count;
        st_nxt.phase     = PH_WR_HIGH;
      end
      PH_ACK_REL: begin
        st_nxt.sda   = 1'b1;
        st_nxt.phase = PH_ACK_CLK;
      end
      PH_ACK_CLK: begin
        st_nxt.scl        = 1'b1;
        st_nxt.wait_count = 8'd0;
        st_nxt.phase      = PH_ACK_POLL;
      end
      PH_ACK_POLL: begin
        if (!tick.sda_sample) begin
          st_nxt.scl = 1'b0;
          flags.done = 1'b1;
        end else if (st.wait_count >= ack_timeout) begin
          flags.done   = 1'b1;
          flags.status = 1'b1;
        end else begin
          st_nxt.wait_count = st.wait_count + 8'd1;
        end
      end
      PH_RD_HIGH: begin
        st_nxt.scl       = 1'b1;
        st_nxt.shift_reg = {st.shift_reg[BITS_PER_BYTE-2:0], tick.sda_sample};
        st_nxt.bit_count = rd_count;
        st_nxt.phase     = (rd_count >= BIT_COUNT_LAST) ? PH_RA_HIGH : PH_RD_LOW;
      end
      PH_RD_LOW: begin
        st_nxt.scl   = 1'b0;
        st_nxt.phase = PH_RD_HIGH;
      end
      PH_RA_HIGH: begin
        st_nxt.scl   = 1'b0;
        st_nxt.sda   = ~st.ack_choice;
        st_nxt.phase = PH_RA_END;
      end
      PH_RA_END: begin
        if (!st.scl) begin
          st_nxt.scl = 1'b1;
        end else begin
          st_nxt.scl     = 1'b0;
          st_nxt.rx_hold = st.shift_reg;
          flags.done     = 1'b1;
        end
      end
      default: begin
        st_nxt.phase = PH_IDLE;
        flags.busy   = 1'b0;
      end
    endcase
    if (flags.done) begin
      st_nxt.phase = PH_IDLE;
    end
  end

endmodule

// ===== hw/rtl/i2c_master_bit_engine.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine
// Byte-level I2C master driven by one bus timing tick per beat.
// ----------------------------------------------------------------------------
// Each input beat is one bus tick and yields exactly one result beat. The
// engine takes a beat in every cycle while the output side is not stalled:
// a beat is held in an input register, the step logic advances the bus
// state by one tick, and the result is registered in an output register.
// The rate of one beat per cycle is set by the feedback of the engine state
// register.
module i2c_master_bit_engine (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_func,
  input  logic [7:0] in_tx_byte,
  input  logic       in_ack_after_read,
  input  logic       in_sda_sample,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_scl_level,
  output logic       out_sda_level,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic       out_status,
  output logic [7:0] out_rx_byte
);
  import i2cm_pkg::*;

  logic        [7:0] ack_timeout_r;
  logic              stg_valid_r;
  tick_t             stg_tick_r;
  eng_state_t        state_r;
  eng_state_t        state_nxt;
  step_flags_t       flags;
  logic              out_valid_r;
  logic              out_scl_r;
  logic              out_sda_r;
  step_flags_t       out_flags_r;
  logic        [7:0] out_rx_r;
  logic              advance;
  logic              in_accept;

  assign advance   = stg_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !stg_valid_r || advance;
  assign in_accept = in_valid && in_ready;

  i2cm_step u_step (
    .st          (state_r),
    .tick        (stg_tick_r),
    .ack_timeout (ack_timeout_r),
    .st_nxt      (state_nxt),
    .flags       (flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      ack_timeout_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stg_tick_r <= '{func: in_func, tx_byte: in_tx_byte,
                      ack_after_read: in_ack_after_read, sda_sample: in_sda_sample};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ENG_STATE_RST;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_scl_r   <= state_nxt.scl;
      out_sda_r   <= state_nxt.sda;
      out_flags_r <= flags;
      out_rx_r    <= state_nxt.rx_hold;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_scl_level = out_scl_r;
  assign out_sda_level = out_sda_r;
  assign out_busy_res  = out_flags_r.busy;
  assign out_done_res  = out_flags_r.done;
  assign out_status    = out_flags_r.status;
  assign out_rx_byte   = out_rx_r;

  a_done_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_flags_r.done |-> out_flags_r.busy)
    else $error("done reported on a tick that was not busy");

  a_status_done : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_flags_r.status |-> out_flags_r.done)
    else $error("NACK status reported without done");

  a_done_idle : assert property (@(posedge clk) disable iff (!rst_n)
    advance && flags.done |=> state_r.phase == PH_IDLE)
    else $error("engine not idle after a finished command");

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !stg_valid_r)
    else $error("pipeline holds a beat after reset");

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Drives bus ticks through the engine and follows every tick with a model of
// the bus sequencer, so that each result beat is checked against the levels,
// flags and received byte that the model predicts. Directed commands cover
// start, stop, write and read, the acknowledge timeout at its extremes and
// unknown commands. Random traffic follows under several idling patterns.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cm_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic       status;
    logic [7:0] rx;
  } bus_result_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] in_func;
  logic [7:0] in_tx_byte;
  logic       in_ack_after_read;
  logic       in_sda_sample;
  logic       out_valid;
  logic       out_ready;
  logic       out_scl_level;
  logic       out_sda_level;
  logic       out_busy_res;
  logic       out_done_res;
  logic       out_status;
  logic [7:0] out_rx_byte;

  phase_t     bus_phase;
  logic [3:0] bits_done;
  logic [7:0] shifter;
  logic [7:0] poll_count;
  logic [7:0] ack_limit;
  logic [7:0] rx_last;
  logic       ack_sel;
  logic       scl_drive;
  logic       sda_drive;

  bus_result_t levels_due[$];
  int          mismatches;
  int          idle_cycles;
  int          send_idle_pct;
  int          stall_pct;

  i2c_master_bit_engine dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_tx_byte        (in_tx_byte),
    .in_ack_after_read (in_ack_after_read),
    .in_sda_sample     (in_sda_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_scl_level     (out_scl_level),
    .out_sda_level     (out_sda_level),
    .out_busy_res      (out_busy_res),
    .out_done_res      (out_done_res),
    .out_status        (out_status),
    .out_rx_byte       (out_rx_byte)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic reset_bus_model();
    bus_phase  = PH_IDLE;
    bits_done  = '0;
    shifter    = '0;
    poll_count = '0;
    ack_limit  = ACK_TIMEOUT_RST;
    rx_last    = '0;
    ack_sel    = 1'b0;
    scl_drive  = 1'b1;
    sda_drive  = 1'b1;
  endtask

  function automatic bus_result_t advance_bus(input tick_t t);
    logic        busy;
    logic        done;
    logic        nack;
    bus_result_t r;
    busy = 1'b1;
    done = 1'b0;
    nack = 1'b0;
    case (bus_phase)
      PH_IDLE: begin
        busy = 1'b0;
        case (t.func)
          FUNC_START: begin
            busy = 1'b1;
            sda_drive = 1'b1;
            scl_drive = 1'b1;
            bus_phase = PH_START_B;
          end
          FUNC_STOP: begin
            busy = 1'b1;
            sda_drive = 1'b0;
            scl_drive = 1'b0;
            bus_phase = PH_STOP_B;
          end
          FUNC_WRITE: begin
            busy = 1'b1;
            scl_drive = 1'b0;
            sda_drive = t.tx_byte[7];
            shifter = t.tx_byte << 1;
            bits_done = 4'd1;
            bus_phase = PH_WR_HIGH;
          end
          FUNC_READ: begin
            busy = 1'b1;
            sda_drive = 1'b1;
            scl_drive = 1'b0;
            shifter = '0;
            bits_done = '0;
            ack_sel = t.ack_after_read;
            bus_phase = PH_RD_HIGH;
          end
          default: ;
        endcase
      end
      PH_START_B: begin
        sda_drive = 1'b0;
        bus_phase = PH_START_C;
      end
      PH_START_C: begin
        scl_drive = 1'b0;
        done = 1'b1;
      end
      PH_STOP_B: begin
        scl_drive = 1'b1;
        bus_phase = PH_STOP_C;
      end
      PH_STOP_C: begin
        sda_drive = 1'b1;
        done = 1'b1;
      end
      PH_WR_HIGH: begin
        scl_drive = 1'b1;
        bus_phase = PH_WR_LOW;
      end
      PH_WR_LOW: begin
        scl_drive = 1'b0;
        bus_phase = (bits_done >= BIT_COUNT_LAST) ? PH_ACK_REL : PH_WR_DATA;
      end
      PH_WR_DATA: begin
        sda_drive = shifter[7];
        shifter = shifter << 1;
        bits_done = bits_done + 4'd1;
        bus_phase = PH_WR_HIGH;
      end
      PH_ACK_REL: begin
        sda_drive = 1'b1;
        bus_phase = PH_ACK_CLK;
      end
      PH_ACK_CLK: begin
        scl_drive = 1'b1;
        poll_count = '0;
        bus_phase = PH_ACK_POLL;
      end
      PH_ACK_POLL: begin
        if (!t.sda_sample) begin
          scl_drive = 1'b0;
          done = 1'b1;
        end else if (poll_count >= ack_limit) begin
          done = 1'b1;
          nack = 1'b1;
        end else begin
          poll_count = poll_count + 8'd1;
        end
      end
      PH_RD_HIGH: begin
        scl_drive = 1'b1;
        shifter = {shifter[6:0], t.sda_sample};
        bits_done = bits_done + 4'd1;
        bus_phase = (bits_done >= BIT_COUNT_LAST) ? PH_RA_HIGH : PH_RD_LOW;
      end
      PH_RD_LOW: begin
        scl_drive = 1'b0;
        bus_phase = PH_RD_HIGH;
      end
      PH_RA_HIGH: begin
        scl_drive = 1'b0;
        sda_drive = !ack_sel;
        bus_phase = PH_RA_END;
      end
      PH_RA_END: begin
        if (!scl_drive) begin
          scl_drive = 1'b1;
        end else begin
          scl_drive = 1'b0;
          rx_last = shifter;
          done = 1'b1;
        end
      end
      default: begin
        bus_phase = PH_IDLE;
        busy = 1'b0;
      end
    endcase
    if (done) bus_phase = PH_IDLE;
    r = '{scl_drive, sda_drive, busy, done, nack, rx_last};
    return r;
  endfunction

  task automatic send_tick(input logic [2:0] func, input logic [7:0] tx,
                           input logic ack, input logic sda);
    tick_t t;
    t = '{func, tx, ack, sda};
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_func           <= func;
    in_tx_byte        <= tx;
    in_ack_after_read <= ack;
    in_sda_sample     <= sda;
    do @(posedge clk); while (!in_ready);
    levels_due.push_back(advance_bus(t));
  endtask

  // The acknowledge is given on the poll numbered ack_at; a negative value
  // keeps SDA high so that the timeout runs out.
  task automatic run_command(input logic [2:0] func, input logic [7:0] tx,
                             input logic ack, input logic [7:0] rx_bits,
                             input int ack_at);
    int   polls;
    logic level;
    polls = 0;
    send_tick(func, tx, ack, 1'($urandom_range(1)));
    while (bus_phase != PH_IDLE) begin
      if (bus_phase == PH_ACK_POLL) begin
        level = (polls == ack_at) ? 1'b0 : 1'b1;
        polls++;
      end else if (bus_phase == PH_RD_HIGH) begin
        level = rx_bits[7 - int'(bits_done)];
      end else begin
        level = 1'($urandom_range(1));
      end
      send_tick(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)), level);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_ack_timeout(input logic [7:0] value);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    ack_limit = value;
  endtask

  task automatic test_reset_timeout();
    run_command(FUNC_WRITE, 8'h96, 1'b0, 8'h00, -1);
    run_command(FUNC_WRITE, 8'h69, 1'b0, 8'h00, 3);
  endtask

  task automatic test_bus_conditions();
    run_command(FUNC_START, 8'h00, 1'b0, 8'h00, 0);
    run_command(FUNC_NONE, 8'hFF, 1'b1, 8'h00, 0);
    run_command(3'd5, 8'h00, 1'b0, 8'h00, 0);
    run_command(3'd6, 8'hFF, 1'b1, 8'h00, 0);
    run_command(3'd7, 8'h5A, 1'b0, 8'h00, 0);
    run_command(FUNC_STOP, 8'hFF, 1'b1, 8'h00, 0);
  endtask

  task automatic test_write_read();
    set_ack_timeout(8'd4);
    run_command(FUNC_WRITE, 8'h00, 1'b0, 8'h00, 0);
    run_command(FUNC_WRITE, 8'hFF, 1'b1, 8'h00, 2);
    run_command(FUNC_WRITE, 8'hA5, 1'b0, 8'h00, -1);
    run_command(FUNC_READ, 8'h00, 1'b1, 8'hFF, 0);
    run_command(FUNC_READ, 8'hFF, 1'b0, 8'h00, 0);
    run_command(FUNC_READ, 8'h3C, 1'b1, 8'h5A, 0);
  endtask

  task automatic test_timeout_extremes();
    set_ack_timeout(8'd0);
    run_command(FUNC_WRITE, 8'h3C, 1'b0, 8'h00, -1);
    run_command(FUNC_WRITE, 8'hC3, 1'b0, 8'h00, 0);
    set_ack_timeout(8'd255);
    run_command(FUNC_WRITE, 8'h7E, 1'b0, 8'h00, 2);
  endtask

  task automatic random_ticks(input int count);
    logic [2:0] func;
    logic       level;
    int         pick;
    for (int i = 0; i < count; i++) begin
      if (bus_phase == PH_IDLE) begin
        pick = $urandom_range(99);
        if (pick < 3) func = FUNC_NONE;
        else if (pick < 8) func = 3'($urandom_range(5, 7));
        else func = 3'($urandom_range(FUNC_START, FUNC_READ));
      end else begin
        func = 3'($urandom_range(7));
      end
      if (bus_phase == PH_ACK_POLL) level = ($urandom_range(3) != 0);
      else level = 1'($urandom_range(1));
      send_tick(func, 8'($urandom), 1'($urandom_range(1)), level);
    end
    while (bus_phase != PH_IDLE) begin
      send_tick(FUNC_NONE, 8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 0;
    stall_pct     = 0;
    set_ack_timeout(8'($urandom_range(1, 12)));
    random_ticks(30);
    send_idle_pct = 76;
    set_ack_timeout(8'($urandom_range(0, 8)));
    random_ticks(30);
    send_idle_pct = 0;
    stall_pct     = 76;
    set_ack_timeout(8'($urandom_range(2, 16)));
    random_ticks(30);
    send_idle_pct = 7;
    stall_pct     = 7;
    set_ack_timeout(8'($urandom_range(1, 10)));
    random_ticks(30);
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic report_beat(input string what, input bus_result_t want,
                             input bus_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected scl %b sda %b busy %b done %b status %b rx %h,",
               what, want.scl, want.sda, want.busy, want.done, want.status, want.rx);
      $display("  got scl %b sda %b busy %b done %b status %b rx %h",
               got.scl, got.sda, got.busy, got.done, got.status, got.rx);
    end
  endtask

  always @(posedge clk) begin : check_beat
    bus_result_t got;
    bus_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_scl_level, out_sda_level, out_busy_res, out_done_res, out_status,
              out_rx_byte};
      if (levels_due.size() == 0) begin
        report_beat("unexpected result beat", '0, got);
      end else begin
        want = levels_due.pop_front();
        if (got.scl !== want.scl || got.sda !== want.sda || got.busy !== want.busy ||
            got.done !== want.done || got.status !== want.status ||
            got.rx !== want.rx) begin
          report_beat("result mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_valid          = 1'b0;
    in_func           = FUNC_NONE;
    in_tx_byte        = '0;
    in_ack_after_read = 1'b0;
    in_sda_sample     = 1'b0;
    mismatches        = 0;
    idle_cycles       = 0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    reset_bus_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_timeout();
    test_bus_conditions();
    test_write_read();
    test_timeout_extremes();
    test_random_traffic();
    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_step.sv
hw/rtl/i2c_master_bit_engine.sv
tb/sv/tb.sv
